// ===== hw/rtl/acm_pkg.sv =====
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types and constants of the adjacent column hit merger.
// ----------------------------------------------------------------------------
package acm_pkg;

  localparam int unsigned ColW  = 7;
  localparam int unsigned RowW  = 3;
  localparam int unsigned TimeW = 16;
  localparam int unsigned TagW  = 16;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_MERGE_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TIME_WINDOW  = 2'd1;

  localparam logic [TimeW-1:0] TIME_WINDOW_RST = 16'd80;

  typedef struct packed {
    logic [ColW-1:0]         column;
    logic [RowW-1:0]         row;
    logic                    amp;
    logic signed [TimeW-1:0] time_v;
    logic [TagW-1:0]         tag;
  } hit_t;

  localparam int unsigned HitW = $bits(hit_t);

  typedef struct packed {
    hit_t hit;
    logic none_kept;
    logic overflow;
    logic last_result;
  } result_t;

  localparam int unsigned ResW = $bits(result_t);

  typedef struct packed {
    logic last;
    logic ovf;
  } ord_flags_t;

  typedef enum logic [1:0] {
    F_LOAD,
    F_SCAN,
    F_PUSH,
    F_WAIT
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HIT,
    B_SREQ,
    B_SCHK,
    B_EMIT,
    B_FIN
  } back_state_e;

endpackage

// ===== hw/rtl/acm_ram.sv =====
// ----------------------------------------------------------------------------
// acm_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module acm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hw/rtl/acm_fifo.sv =====
// ----------------------------------------------------------------------------
// acm_fifo
// Small first-in first-out queue on flops.
// ----------------------------------------------------------------------------
module acm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [AW:0]      wptr_q, rptr_q;

  assign empty_o = (wptr_q == rptr_q);
  assign full_o  = (wptr_q[AW-1:0] == rptr_q[AW-1:0]) && (wptr_q[AW] != rptr_q[AW]);
  assign rdata_o = data_q[rptr_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      data_q[wptr_q[AW-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/acm_front.sv =====
// ----------------------------------------------------------------------------
// acm_front
// Loads an event's hits and emits their indices in stable column order.
// ----------------------------------------------------------------------------
module acm_front
  import acm_pkg::*;
#(
  parameter int unsigned MAX_HITS    = 64,
  parameter int unsigned COLUMN_BITS = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  hit_t                           hit_i,
  input  logic                           last_i,
  output logic                           ram_we_o,
  output logic [$clog2(MAX_HITS)-1:0]    ram_waddr_o,
  output hit_t                           ram_wdata_o,
  output logic [$clog2(MAX_HITS)-1:0]    ram_raddr_o,
  input  hit_t                           ram_rdata_i,
  output logic                           ord_push_o,
  output logic [$clog2(MAX_HITS)-1:0]    ord_idx_o,
  output ord_flags_t                     ord_flags_o,
  input  logic                           ord_full_i,
  output logic [$clog2(MAX_HITS+1)-1:0]  count_o,
  input  logic                           done_i
);

  localparam int unsigned IW = $clog2(MAX_HITS);
  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam int unsigned KW = ColW + IW;
  localparam logic [ColW-1:0] ColMask =
    (COLUMN_BITS >= ColW) ? {ColW{1'b1}} : ColW'((1 << COLUMN_BITS) - 1);

  front_state_e    state_q, state_d;
  logic [CW-1:0]   cnt_q, k_q, emit_q;
  logic            ovf_q, rv_q, best_v_q, first_q;
  logic [IW-1:0]   ridx_q;
  logic [KW-1:0]   best_key_q, last_key_q, cand_key;
  logic            accept, cand_ok, ord_last;

  assign full_o      = (state_q != F_LOAD);
  assign accept      = push_i && !full_o;
  assign ram_we_o    = accept && (cnt_q < CW'(MAX_HITS));
  assign ram_waddr_o = cnt_q[IW-1:0];
  assign count_o     = cnt_q;

  always_comb begin
    ram_wdata_o        = hit_i;
    ram_wdata_o.column = hit_i.column & ColMask;
  end

  assign ram_raddr_o = k_q[IW-1:0];
  assign cand_key    = {ram_rdata_i.column, ridx_q};
  assign cand_ok     = rv_q && (first_q || (cand_key > last_key_q))
                       && (!best_v_q || (cand_key < best_key_q));
  assign ord_last    = (emit_q == (cnt_q - 1'b1));

  always_comb begin
    ord_push_o        = (state_q == F_PUSH) && !ord_full_i;
    ord_idx_o         = best_key_q[IW-1:0];
    ord_flags_o.last  = ord_last;
    ord_flags_o.ovf   = ovf_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_LOAD: if (accept && last_i) state_d = F_SCAN;
      F_SCAN: if ((k_q == cnt_q) && !rv_q) state_d = F_PUSH;
      F_PUSH: if (!ord_full_i) state_d = ord_last ? F_WAIT : F_SCAN;
      F_WAIT: if (done_i) state_d = F_LOAD;
      default: state_d = F_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_LOAD;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      k_q        <= '0;
      rv_q       <= 1'b0;
      ridx_q     <= '0;
      best_v_q   <= 1'b0;
      best_key_q <= '0;
      last_key_q <= '0;
      first_q    <= 1'b1;
      emit_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        F_LOAD: begin
          if (accept) begin
            if (cnt_q < CW'(MAX_HITS)) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
          end
          k_q      <= '0;
          rv_q     <= 1'b0;
          best_v_q <= 1'b0;
          first_q  <= 1'b1;
          emit_q   <= '0;
        end
        F_SCAN: begin
          if (k_q < cnt_q) begin
            k_q    <= k_q + 1'b1;
            rv_q   <= 1'b1;
            ridx_q <= k_q[IW-1:0];
          end else begin
            rv_q <= 1'b0;
          end
          if (cand_ok) begin
            best_v_q   <= 1'b1;
            best_key_q <= cand_key;
          end
        end
        F_PUSH: begin
          if (!ord_full_i) begin
            last_key_q <= best_key_q;
            first_q    <= 1'b0;
            emit_q     <= emit_q + 1'b1;
            best_v_q   <= 1'b0;
            k_q        <= '0;
          end
        end
        F_WAIT: begin
          if (done_i) begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/acm_back.sv =====
// ----------------------------------------------------------------------------
// acm_back
// Walks hits in sorted order, applies neighbor absorption, builds results.
// ----------------------------------------------------------------------------
module acm_back
  import acm_pkg::*;
#(
  parameter int unsigned MAX_HITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          merge_en_i,
  input  logic [TimeW-1:0]              window_i,
  input  logic [$clog2(MAX_HITS+1)-1:0] count_i,
  input  logic                          ord_empty_i,
  output logic                          ord_pop_o,
  input  logic [$clog2(MAX_HITS)-1:0]   ord_idx_i,
  input  ord_flags_t                    ord_flags_i,
  output logic [$clog2(MAX_HITS)-1:0]   ram_raddr_o,
  input  hit_t                          ram_rdata_i,
  output logic                          res_push_o,
  output result_t                       res_o,
  input  logic                          res_full_i,
  output logic                          done_o
);

  localparam int unsigned IW = $clog2(MAX_HITS);
  localparam int unsigned CW = $clog2(MAX_HITS + 1);

  back_state_e          state_q, state_d;
  logic [IW-1:0]        idx_q;
  ord_flags_t           flags_q;
  hit_t                 hit_q, pend_q;
  logic                 pend_v_q, keep_q;
  logic [CW-1:0]        j_q;
  logic [MAX_HITS-1:0]  absorbed_q;
  logic                 keep, scan, match;
  logic signed [TimeW:0] dt;
  logic [TimeW:0]       adt;

  assign keep = (ram_rdata_i.row != '0) || !merge_en_i
                || (ram_rdata_i.amp && !absorbed_q[idx_q]);
  assign scan = merge_en_i && (ram_rdata_i.row == '0) && ram_rdata_i.amp
                && !absorbed_q[idx_q];

  assign dt    = (TimeW+1)'(hit_q.time_v) - (TimeW+1)'(ram_rdata_i.time_v);
  assign adt   = dt[TimeW] ? (TimeW+1)'(-dt) : (TimeW+1)'(dt);
  assign match = ram_rdata_i.amp && (ram_rdata_i.row == '0)
                 && ({1'b0, ram_rdata_i.column} == ({1'b0, hit_q.column} + 1'b1))
                 && (adt <= {1'b0, window_i});

  always_comb begin
    ord_pop_o   = (state_q == B_IDLE) && !ord_empty_i;
    ram_raddr_o = (state_q == B_IDLE) ? ord_idx_i : j_q[IW-1:0];
    res_push_o  = 1'b0;
    res_o       = '0;
    done_o      = 1'b0;
    case (state_q)
      B_EMIT: begin
        res_push_o      = keep_q && pend_v_q && !res_full_i;
        res_o.hit       = pend_q;
        res_o.overflow  = flags_q.ovf;
      end
      B_FIN: begin
        res_push_o        = !res_full_i;
        res_o.hit         = pend_v_q ? pend_q : '0;
        res_o.none_kept   = !pend_v_q;
        res_o.overflow    = flags_q.ovf;
        res_o.last_result = 1'b1;
        done_o            = !res_full_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!ord_empty_i) state_d = B_HIT;
      B_HIT:  state_d = scan ? B_SREQ : B_EMIT;
      B_SREQ: state_d = B_SCHK;
      B_SCHK: begin
        if (match || ((j_q + 1'b1) == count_i)) begin
          state_d = B_EMIT;
        end else begin
          state_d = B_SREQ;
        end
      end
      B_EMIT: begin
        if (!(keep_q && pend_v_q) || !res_full_i) begin
          state_d = flags_q.last ? B_FIN : B_IDLE;
        end
      end
      B_FIN:  if (!res_full_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == B_IDLE) && !ord_empty_i) begin
      idx_q   <= ord_idx_i;
      flags_q <= ord_flags_i;
    end
    if (state_q == B_HIT) begin
      hit_q  <= ram_rdata_i;
      keep_q <= keep;
    end
    if ((state_q == B_EMIT) && keep_q && (!pend_v_q || !res_full_i)) begin
      pend_q <= hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      pend_v_q   <= 1'b0;
      j_q        <= '0;
      absorbed_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        B_HIT: j_q <= '0;
        B_SCHK: begin
          if (match) begin
            absorbed_q[j_q[IW-1:0]] <= 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        B_EMIT: begin
          if (keep_q && (!pend_v_q || !res_full_i)) begin
            pend_v_q <= 1'b1;
          end
        end
        B_FIN: begin
          if (!res_full_i) begin
            pend_v_q   <= 1'b0;
            absorbed_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/adjacent_column_hit_merger.sv =====
// ----------------------------------------------------------------------------
// adjacent_column_hit_merger
// Collects an event's hits, sorts them by column and drops neighbor hits.
// ----------------------------------------------------------------------------
// Timing: hits load one per cycle while full is low; after the last hit the
// sorter makes one full RAM pass per output, and the back end runs the
// neighbor scan for each hit that needs it, then emits one closing result
// for the event.
// Throughput: one event at a time.
// Reset: asynchronous, clears control state; merge_enable=1, time_window=80.
// ----------------------------------------------------------------------------
module adjacent_column_hit_merger
  import acm_pkg::*;
#(
  parameter int unsigned MAX_HITS    = 64,
  parameter int unsigned COLUMN_BITS = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_wdata_i,
  input  logic                    push,
  output logic                    full,
  input  logic [ColW-1:0]         column_i,
  input  logic [RowW-1:0]         row_i,
  input  logic                    has_amplitude_i,
  input  logic signed [TimeW-1:0] hit_time_i,
  input  logic [TagW-1:0]         hit_tag_i,
  input  logic                    last_in_event_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [ColW-1:0]         out_column_o,
  output logic [RowW-1:0]         out_row_o,
  output logic                    out_has_amplitude_o,
  output logic signed [TimeW-1:0] out_time_o,
  output logic [TagW-1:0]         out_tag_o,
  output logic                    none_kept_o,
  output logic                    overflow_o,
  output logic                    last_result_o
);

  localparam int unsigned IW = $clog2(MAX_HITS);
  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam int unsigned OrdW = IW + $bits(ord_flags_t);

  logic             merge_en_q;
  logic [TimeW-1:0] window_q;

  hit_t          in_hit, ram_wdata, rdata_a, rdata_b;
  logic          ram_we;
  logic [IW-1:0] ram_waddr, raddr_a, raddr_b;
  logic          ord_push, ord_full, ord_pop, ord_empty;
  logic [IW-1:0] ord_idx_w, ord_idx_r;
  ord_flags_t    ord_flags_w, ord_flags_r;
  logic [CW-1:0] count;
  logic          done;
  logic          res_push, res_full;
  result_t       res_w, res_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_en_q <= 1'b1;
      window_q   <= TIME_WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MERGE_ENABLE: merge_en_q <= cfg_wdata_i[0];
        REG_TIME_WINDOW:  window_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_hit.column = column_i;
    in_hit.row    = row_i;
    in_hit.amp    = has_amplitude_i;
    in_hit.time_v = hit_time_i;
    in_hit.tag    = hit_tag_i;
  end

  acm_ram #(.WIDTH(HitW), .DEPTH(MAX_HITS)) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  acm_front #(.MAX_HITS(MAX_HITS), .COLUMN_BITS(COLUMN_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .hit_i       (in_hit),
    .last_i      (last_in_event_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (raddr_a),
    .ram_rdata_i (rdata_a),
    .ord_push_o  (ord_push),
    .ord_idx_o   (ord_idx_w),
    .ord_flags_o (ord_flags_w),
    .ord_full_i  (ord_full),
    .count_o     (count),
    .done_i      (done)
  );

  acm_fifo #(.WIDTH(OrdW), .DEPTH(4)) u_ord_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ord_push),
    .wdata_i ({ord_idx_w, ord_flags_w}),
    .full_o  (ord_full),
    .pop_i   (ord_pop),
    .rdata_o ({ord_idx_r, ord_flags_r}),
    .empty_o (ord_empty)
  );

  acm_back #(.MAX_HITS(MAX_HITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .merge_en_i  (merge_en_q),
    .window_i    (window_q),
    .count_i     (count),
    .ord_empty_i (ord_empty),
    .ord_pop_o   (ord_pop),
    .ord_idx_i   (ord_idx_r),
    .ord_flags_i (ord_flags_r),
    .ram_raddr_o (raddr_b),
    .ram_rdata_i (rdata_b),
    .res_push_o  (res_push),
    .res_o       (res_w),
    .res_full_i  (res_full),
    .done_o      (done)
  );

  acm_fifo #(.WIDTH(ResW), .DEPTH(4)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_w),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_r),
    .empty_o (empty)
  );

  assign out_column_o        = res_r.hit.column;
  assign out_row_o           = res_r.hit.row;
  assign out_has_amplitude_o = res_r.hit.amp;
  assign out_time_o          = res_r.hit.time_v;
  assign out_tag_o           = res_r.hit.tag;
  assign none_kept_o         = res_r.none_kept;
  assign overflow_o          = res_r.overflow;
  assign last_result_o       = res_r.last_result;

endmodule
